/* design/tlbpt_pkg.sv */
// ============================================================================
// tlbpt_pkg - shared constants and types for the TLB page-table translator
// Address widths, table sizes and the control bundles between top and TLB.
// ============================================================================
package tlbpt_pkg;

    localparam int VA_W        = 16;
    localparam int PA_W        = 15;
    localparam int OFFSET_W    = 8;
    localparam int PAGE_W      = 8;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_W     = 7;
    localparam int FRAME_COUNT = 128;
    localparam int TLB_DEPTH   = 16;
    localparam int TLB_IDX_W   = 4;

    localparam logic [FRAME_W-1:0]   FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
    localparam logic [TLB_IDX_W-1:0] TLB_LAST   = TLB_IDX_W'(TLB_DEPTH - 1);

    // Lookup result from the TLB
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_look;

    // Update request to the TLB, applied on the commit cycle of a miss
    typedef struct packed {
        logic               fill;      // append a new entry at the fill pointer
        logic               evict;     // retarget first entry naming victim_page
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  victim_page;
    } t_tlb_upd;

endpackage

/* design/tlbpt_if.sv */
// ============================================================================
// tlbpt_if - valid/ready channels of the translator
// Virtual address item in, translated physical address item out.
// ============================================================================
interface tlbpt_va_if;
    logic                        valid;
    logic                        ready;
    logic [tlbpt_pkg::VA_W-1:0]  vaddr;

    modport source (output valid, output vaddr, input ready);
    modport sink   (input valid, input vaddr, output ready);
endinterface

interface tlbpt_pa_if;
    logic                          valid;
    logic                          ready;
    logic [tlbpt_pkg::PA_W-1:0]    paddr;
    logic                          tlb_hit;
    logic                          page_fault;
    logic                          evicted_valid;
    logic [tlbpt_pkg::PAGE_W-1:0]  evicted_page;

    modport source (output valid, output paddr, output tlb_hit,
                    output page_fault, output evicted_valid, output evicted_page,
                    input ready);
    modport sink   (input valid, input paddr, input tlb_hit,
                    input page_fault, input evicted_valid, input evicted_page,
                    output ready);
endinterface

/* design/tlbpt_tlb.sv */
// ============================================================================
// tlbpt_tlb - fully associative TLB with FIFO fill
// Lowest matching valid entry wins. On an eviction the first entry naming
// the displaced page is retargeted; a fill then writes at the fill pointer.
// ============================================================================
module tlbpt_tlb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0]      i_page,
    input  tlbpt_pkg::t_tlb_upd               i_upd,
    output tlbpt_pkg::t_tlb_look              o_look
);

    logic                              r_valid [tlbpt_pkg::TLB_DEPTH];
    logic [tlbpt_pkg::PAGE_W-1:0]      r_page  [tlbpt_pkg::TLB_DEPTH];
    logic [tlbpt_pkg::FRAME_W-1:0]     r_frame [tlbpt_pkg::TLB_DEPTH];
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   r_fill_ptr;
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   n_fill_ptr;

    logic                              rw_found;
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   rw_idx;

    // Look up the page, lowest index first
    always_comb begin
        o_look.hit   = 1'b0;
        o_look.frame = '0;
        for (int i = tlbpt_pkg::TLB_DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page[i] == i_page)) begin
                o_look.hit   = 1'b1;
                o_look.frame = r_frame[i];
            end
        end
    end

    // Find the first entry that still names the displaced page
    always_comb begin
        rw_found = 1'b0;
        rw_idx   = '0;
        for (int i = tlbpt_pkg::TLB_DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page[i] == i_upd.victim_page)) begin
                rw_found = 1'b1;
                rw_idx   = tlbpt_pkg::TLB_IDX_W'(i);
            end
        end
    end

    // Advance the fill pointer with wrap
    always_comb begin
        n_fill_ptr = r_fill_ptr;
        if (i_upd.fill) begin
            n_fill_ptr = (r_fill_ptr == tlbpt_pkg::TLB_LAST) ? '0 : r_fill_ptr + 1'b1;
        end
    end

    // Valid bits and fill pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_ptr <= '0;
            for (int i = 0; i < tlbpt_pkg::TLB_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_fill_ptr <= n_fill_ptr;
            if (i_upd.fill) begin
                r_valid[r_fill_ptr] <= 1'b1;
            end
        end
    end

    // Entry payload: retarget first, the fill overrides on the same entry
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tlbpt_pkg::TLB_DEPTH; i++) begin
            if (i_upd.fill && (r_fill_ptr == tlbpt_pkg::TLB_IDX_W'(i))) begin
                r_page[i]  <= i_upd.page;
                r_frame[i] <= i_upd.frame;
            end else if (i_upd.evict && rw_found && (rw_idx == tlbpt_pkg::TLB_IDX_W'(i))) begin
                r_page[i]  <= i_upd.page;
                r_frame[i] <= i_upd.frame;
            end
        end
    end

endmodule

/* design/tlb_page_table_translator_core.sv */
// ============================================================================
// tlb_page_table_translator_core - virtual to physical address translation
// The accepted item is captured with its page-table and frame-owner reads;
// on commit, once the output register is free, the result is loaded into it.
// A new item is taken only after the previous one commits: the page-table and
// frame-owner RAM read comes first, then the read-modify-write commit.
// Reset: TLB, page-table valid bits, frame pointer and wrap flag clear at once;
// no clearing pass is needed.
// ============================================================================
module tlb_page_table_translator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlbpt_va_if.sink    i_va_ch,
    tlbpt_pa_if.source  o_pa_ch
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                            r_state, n_state;

    logic [tlbpt_pkg::PAGE_W-1:0]      r_page;
    logic [tlbpt_pkg::OFFSET_W-1:0]    r_offset;
    logic [tlbpt_pkg::FRAME_W-1:0]     r_frame_ptr;
    logic                              r_frames_all_used;

    // Page table: frame per page in RAM, valid bits in flops
    logic [tlbpt_pkg::FRAME_W-1:0]     r_pm_mem   [tlbpt_pkg::PAGE_COUNT];
    logic                              r_pm_valid [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::FRAME_W-1:0]     r_pm_rd;
    logic                              r_pm_valid_rd;

    // Reverse map: owning page per frame. Only used once the pointer has
    // wrapped, by which time every frame has been written.
    logic [tlbpt_pkg::PAGE_W-1:0]      r_fo_mem [tlbpt_pkg::FRAME_COUNT];
    logic [tlbpt_pkg::PAGE_W-1:0]      r_fo_rd;

    logic                              r_out_valid;
    logic [tlbpt_pkg::PA_W-1:0]        r_out_pa;
    logic                              r_out_hit;
    logic                              r_out_fault;
    logic                              r_out_ev_valid;
    logic [tlbpt_pkg::PAGE_W-1:0]      r_out_ev_page;

    logic                              accept;
    logic                              commit;
    logic                              pm_valid;
    logic                              fault;
    logic                              evict;
    logic [tlbpt_pkg::FRAME_W-1:0]     frame;
    logic [tlbpt_pkg::PAGE_W-1:0]      in_page;
    tlbpt_pkg::t_tlb_look              tlb_look;
    tlbpt_pkg::t_tlb_upd               tlb_upd;

    assign i_va_ch.ready = (r_state == S_IDLE);
    assign accept        = i_va_ch.valid && i_va_ch.ready;
    assign commit        = (r_state == S_EXEC) && (!r_out_valid || o_pa_ch.ready);
    assign in_page       = i_va_ch.vaddr[tlbpt_pkg::VA_W-1:tlbpt_pkg::OFFSET_W];

    // Resolve the translation for the held item
    assign pm_valid = r_pm_valid_rd;
    assign fault    = !tlb_look.hit && !pm_valid;
    assign evict    = fault && r_frames_all_used;

    always_comb begin
        if (tlb_look.hit) begin
            frame = tlb_look.frame;
        end else if (pm_valid) begin
            frame = r_pm_rd;
        end else begin
            frame = r_frame_ptr;
        end
    end

    always_comb begin
        tlb_upd.fill        = commit && !tlb_look.hit;
        tlb_upd.evict       = commit && evict;
        tlb_upd.page        = r_page;
        tlb_upd.frame       = frame;
        tlb_upd.victim_page = r_fo_rd;
    end

    tlbpt_tlb u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_page  (r_page),
        .i_upd   (tlb_upd),
        .o_look  (tlb_look)
    );

    // Sequence: read on accept, write back on commit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_frame_ptr       <= '0;
            r_frames_all_used <= 1'b0;
            r_out_valid       <= 1'b0;
            for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++) begin
                r_pm_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_pa_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit && fault) begin
                if (r_frame_ptr == tlbpt_pkg::FRAME_LAST) begin
                    r_frame_ptr       <= '0;
                    r_frames_all_used <= 1'b1;
                end else begin
                    r_frame_ptr <= r_frame_ptr + 1'b1;
                end
                if (evict) begin
                    r_pm_valid[r_fo_rd] <= 1'b0;
                end
                r_pm_valid[r_page] <= 1'b1;
            end
        end
    end

    // Capture the item and read both memories
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page        <= in_page;
            r_offset      <= i_va_ch.vaddr[tlbpt_pkg::OFFSET_W-1:0];
            r_pm_rd       <= r_pm_mem[in_page];
            r_pm_valid_rd <= r_pm_valid[in_page];
            r_fo_rd       <= r_fo_mem[r_frame_ptr];
        end
    end

    // Write back the new mapping on a fault
    always_ff @(posedge i_clk) begin
        if (commit && fault) begin
            r_pm_mem[r_page]      <= r_frame_ptr;
            r_fo_mem[r_frame_ptr] <= r_page;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_pa       <= {frame, r_offset};
            r_out_hit      <= tlb_look.hit;
            r_out_fault    <= fault;
            r_out_ev_valid <= evict;
            r_out_ev_page  <= evict ? r_fo_rd : '0;
        end
    end

    assign o_pa_ch.valid         = r_out_valid;
    assign o_pa_ch.paddr         = r_out_pa;
    assign o_pa_ch.tlb_hit       = r_out_hit;
    assign o_pa_ch.page_fault    = r_out_fault;
    assign o_pa_ch.evicted_valid = r_out_ev_valid;
    assign o_pa_ch.evicted_page  = r_out_ev_page;

    // A displaced page is only reported with a fault, never with a hit
    a_evict_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_ev_valid || r_out_fault) && !(r_out_hit && r_out_fault))
        else $error("eviction or hit reported inconsistently with fault");

    // Each fault moves the frame pointer by one with wrap
    a_frame_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && fault) |=> (r_frame_ptr == (($past(r_frame_ptr) == tlbpt_pkg::FRAME_LAST)
                                ? '0 : $past(r_frame_ptr) + 1'b1)))
        else $error("frame pointer did not advance on fault");

    // Once all frames are used the flag stays set
    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_all_used |=> r_frames_all_used)
        else $error("frames_all_used cleared");

    // No eviction before the first wrap of the frame pointer
    a_no_early_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !r_frames_all_used) |=> !r_out_ev_valid)
        else $error("eviction before frames wrapped");

endmodule
